// ----- rtl/amh_pkg.sv -----
package amh_pkg;

  localparam int VALUE_BITS = 8;
  localparam int unsigned HIST_DEPTH = 256;
  localparam int unsigned MAX_ITEMS = 4096;

  localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_BITS = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  typedef logic [VALUE_BITS-1:0] slot_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // write-back and end-of-set control toward the count bank
  typedef struct packed {
    logic   en;
    logic   clear;
    addr_t  addr;
    count_t count;
  } amh_wr_t;

endpackage

// ----- rtl/amh_bank.sv -----
module amh_bank
  import amh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  addr_t   rd_addr,
  input  amh_wr_t wr,
  output count_t  rd_count
);

  count_t                mem [HIST_DEPTH];
  count_t                rd_data_r;
  addr_t                 rd_addr_r;
  logic [HIST_DEPTH-1:0] live_r;
  logic                  fwd_valid_r;
  addr_t                 fwd_addr_r;
  count_t                fwd_count_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.count;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // one live bit per entry; clear drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      fwd_valid_r <= 1'b0;
    end else if (wr.clear) begin
      live_r      <= '0;
      fwd_valid_r <= 1'b0;
    end else if (wr.en) begin
      live_r[wr.addr] <= 1'b1;
      fwd_valid_r     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_addr_r  <= wr.addr;
      fwd_count_r <= wr.count;
    end
  end

  // bypass the write that landed on the same edge as the read
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == rd_addr_r)) begin
      rd_count = fwd_count_r;
    end else if (live_r[rd_addr_r]) begin
      rd_count = rd_data_r;
    end else begin
      rd_count = '0;
    end
  end

endmodule

// ----- rtl/array_mode_histogram.sv -----
// Mode, minimum and maximum of a set of signed samples.
//
// Input channel: in_valid / in_stall with in_sample (signed) and in_last.
// A set is a run of words ending in one with in_last high. Each word is
// counted in a histogram memory; the running mode (smallest value among
// those with the highest count), minimum and maximum are kept.
// Result channel: out_valid / out_stall, one word per set carrying
// out_mode_value, out_mode_count, out_min_value and out_max_value.
// Throughput: one input word per cycle while in_stall is low; the histogram
// memory has separate read and write ports and a same-entry hazard is bypassed.
// The last word enters the update stage, then the result register loads from it.
// A set with no counted sample reports mode 0 with count 0.
// Counts saturate at MAX_ITEMS.
// Reset (rst_n low, synchronous) empties the pipeline and the result
// register and marks every histogram entry empty; the block accepts words
// as soon as reset is released. The histogram is emptied again at the end
// of each set without stalling the input.
// When the receiver stalls, the finished result holds; words keep flowing
// until a further last word reaches the update stage, which then holds and
// stalls the input until the result is taken.
module array_mode_histogram
  import amh_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_sample,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_mode_value,
  output logic [COUNT_BITS-1:0]        out_mode_count,
  output logic signed [VALUE_BITS-1:0] out_min_value,
  output logic signed [VALUE_BITS-1:0] out_max_value
);

  localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam count_t COUNT_LIMIT = COUNT_BITS'(MAX_ITEMS);

  logic   in_take;
  slot_t  in_slot;
  logic   in_hit;

  // update stage: the word whose histogram count is being read back
  logic                         s1_valid_r;
  logic signed [VALUE_BITS-1:0] s1_sample_r;
  logic                         s1_last_r;
  logic                         s1_hit_r;
  addr_t                        s1_addr_r;
  logic                         s1_go;

  logic signed [VALUE_BITS-1:0] best_value_r, best_value_nxt;
  count_t                       best_count_r, best_count_nxt;
  logic signed [VALUE_BITS-1:0] low_r, low_nxt;
  logic signed [VALUE_BITS-1:0] high_r, high_nxt;

  logic                         out_valid_r;
  logic signed [VALUE_BITS-1:0] out_mode_value_r;
  count_t                       out_mode_count_r;
  logic signed [VALUE_BITS-1:0] out_min_value_r;
  logic signed [VALUE_BITS-1:0] out_max_value_r;

  count_t  cur_count;
  count_t  new_count;
  logic    take_best;
  amh_wr_t wr;

  // slot = sample + half range: flip the sign bit
  assign in_slot = {~in_sample[VALUE_BITS-1], in_sample[VALUE_BITS-2:0]};
  assign in_hit  = 32'(in_slot) < HIST_DEPTH;

  // hold a last word while the previous result still waits
  assign s1_go    = s1_valid_r && !(s1_last_r && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  amh_bank u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_take),
    .rd_addr  (ADDR_BITS'(in_slot)),
    .wr       (wr),
    .rd_count (cur_count)
  );

  always_comb begin
    new_count = (cur_count < COUNT_LIMIT) ? cur_count + count_t'(1) : cur_count;
    take_best = s1_hit_r && ((new_count > best_count_r) ||
                ((new_count == best_count_r) && (s1_sample_r < best_value_r)));
    best_value_nxt = take_best ? s1_sample_r : best_value_r;
    best_count_nxt = take_best ? new_count : best_count_r;
    low_nxt  = (s1_sample_r < low_r)  ? s1_sample_r : low_r;
    high_nxt = (s1_sample_r > high_r) ? s1_sample_r : high_r;

    wr.en    = s1_go && s1_hit_r;
    wr.clear = s1_go && s1_last_r;
    wr.addr  = s1_addr_r;
    wr.count = new_count;
  end

  // advance the update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last;
      s1_hit_r    <= in_hit;
      s1_addr_r   <= ADDR_BITS'(in_slot);
    end
  end

  // running statistics; start over after each last word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_value_r <= '0;
      best_count_r <= '0;
      low_r        <= MOST_POS;
      high_r       <= MOST_NEG;
    end else if (s1_go) begin
      if (s1_last_r) begin
        best_value_r <= '0;
        best_count_r <= '0;
        low_r        <= MOST_POS;
        high_r       <= MOST_NEG;
      end else begin
        best_value_r <= best_value_nxt;
        best_count_r <= best_count_nxt;
        low_r        <= low_nxt;
        high_r       <= high_nxt;
      end
    end
  end

  // result register: load on a finished set, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_mode_value_r <= best_value_nxt;
      out_mode_count_r <= best_count_nxt;
      out_min_value_r  <= low_nxt;
      out_max_value_r  <= high_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mode_value = out_mode_value_r;
  assign out_mode_count = out_mode_count_r;
  assign out_min_value  = out_min_value_r;
  assign out_max_value  = out_max_value_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_last_r && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> out_valid)
    else $error("finished set produced no result");

  a_mode_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_mode_count != '0)) |->
      ((out_min_value <= out_mode_value) && (out_mode_value <= out_max_value)))
    else $error("mode outside min/max span");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mode_count <= COUNT_LIMIT))
    else $error("mode count above limit");

endmodule
